FILE: rtl/acc7seg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc7seg_pkg
// Shared types, codes and segment tables for the accelerometer readout.
// ----------------------------------------------------------------------------
package acc7seg_pkg;

  localparam logic [15:0] FULL_SCALE_RESET = 16'd32767;
  localparam logic [1:0]  DP_DIGIT         = 2'd1;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic pend_full;
    logic last_step;
  } status_t;

  function automatic logic [6:0] seg_digit(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  function automatic logic [6:0] seg_axis(input logic [1:0] a);
    logic [6:0] s;
    case (a)
      AXIS_X:  s = 7'h76;
      AXIS_Y:  s = 7'h6E;
      AXIS_Z:  s = 7'h5B;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/acc7seg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc7seg_ctrl
// Sequencer: takes a tick, runs the divider, then refreshes the patterns.
// ----------------------------------------------------------------------------
module acc7seg_ctrl
  import acc7seg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = status_i.pend_full;
        if (in_valid_i && !status_i.pend_full) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.step = 1'b1;
        if (status_i.last_step) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/acc7seg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc7seg_dp
// Datapath: button edge, axis select, bit-serial divider, digit patterns,
// result stage.
// ----------------------------------------------------------------------------
module acc7seg_dp
  import acc7seg_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output status_t                status_o,
  input  logic                   full_scale_we_i,
  input  logic [15:0]            full_scale_i,
  input  logic                   push_pressed_i,
  input  logic [SAMPLE_BITS-1:0] accel_x_i,
  input  logic [SAMPLE_BITS-1:0] accel_y_i,
  input  logic [SAMPLE_BITS-1:0] accel_z_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             segment_lines_o,
  output logic [3:0]             digit_enable_o
);

  localparam int NUM_BITS = SAMPLE_BITS + 8;
  localparam int CNT_BITS = $clog2(NUM_BITS);

  logic [15:0]          full_scale_q;
  logic [1:0]           axis_q, axis_d;
  logic                 was_pressed_q, was_pressed_d;
  logic [1:0]           scan_q;
  logic [6:0]           pat_q [4];

  logic [15:0]          div_q;
  logic [NUM_BITS-1:0]  num_q;
  logic [NUM_BITS-1:0]  h_q;
  logic [15:0]          rem_q;
  logic [6:0]           r100_q;
  logic [CNT_BITS-1:0]  cnt_q;

  logic                 pend_valid_q;
  logic [7:0]           pend_seg_q;
  logic [3:0]           pend_en_q;
  logic                 out_valid_q;
  logic [7:0]           out_seg_q;
  logic [3:0]           out_en_q;
  logic                 out_load;

  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] mag;
  logic [NUM_BITS-1:0]    mag_ext;
  logic [NUM_BITS-1:0]    num_init;
  logic [16:0]            trial;
  logic                   qbit;
  logic [15:0]            rem_next;
  logic [7:0]             r100_trial;
  logic [6:0]             r100_next;
  logic [14:0]            tens_prod;
  logic [3:0]             tens;
  logic [6:0]             units_w;
  logic [15:0]            hund_prod;
  logic [3:0]             hund;
  logic                   small_h;

  // button edge and axis cycling
  always_comb begin
    axis_d        = axis_q;
    was_pressed_d = was_pressed_q;
    if (push_pressed_i) begin
      if (!was_pressed_q) begin
        axis_d        = (axis_q == AXIS_X || axis_q == AXIS_Y) ? axis_q + 2'd1 : AXIS_X;
        was_pressed_d = 1'b1;
      end
    end else begin
      was_pressed_d = 1'b0;
    end
  end

  always_comb begin
    case (axis_d)
      AXIS_X:  sample = accel_x_i;
      AXIS_Y:  sample = accel_y_i;
      default: sample = accel_z_i;
    endcase
    mag      = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    mag_ext  = NUM_BITS'(mag);
    num_init = (mag_ext << 7) + (mag_ext << 6) + (mag_ext << 3);
  end

  // one quotient bit per cycle; quotient also folded into a mod-100 remainder
  always_comb begin
    trial      = {rem_q, num_q[NUM_BITS-1]};
    qbit       = trial >= {1'b0, div_q};
    rem_next   = qbit ? 16'(trial - {1'b0, div_q}) : trial[15:0];
    r100_trial = {r100_q, qbit};
    r100_next  = (r100_trial >= 8'd100) ? 7'(r100_trial - 8'd100) : r100_trial[6:0];
  end

  always_comb begin
    tens_prod = 15'(r100_q) * 15'd205;
    tens      = tens_prod[14:11];
    units_w   = r100_q - 7'(tens) * 7'd10;
    hund_prod = 16'(h_q[9:0]) * 16'd41;
    hund      = hund_prod[15:12];
    small_h   = h_q < NUM_BITS'(1000);
  end

  always_comb begin
    status_o.pend_full = pend_valid_q;
    status_o.last_step = cnt_q == CNT_BITS'(NUM_BITS - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q  <= FULL_SCALE_RESET;
      axis_q        <= AXIS_X;
      was_pressed_q <= 1'b0;
      scan_q        <= 2'd0;
      for (int i = 0; i < 4; i++) begin
        pat_q[i] <= 7'd0;
      end
    end else begin
      if (full_scale_we_i) begin
        full_scale_q <= full_scale_i;
      end
      if (cmd_i.accept) begin
        axis_q        <= axis_d;
        was_pressed_q <= was_pressed_d;
        scan_q        <= scan_q + 2'd1;
        if (axis_d == AXIS_X || axis_d == AXIS_Y || axis_d == AXIS_Z) begin
          pat_q[0] <= seg_axis(axis_d);
        end
      end
      if (cmd_i.finish) begin
        if (small_h) begin
          pat_q[1] <= seg_digit(hund);
        end
        pat_q[2] <= seg_digit(tens);
        pat_q[3] <= seg_digit(units_w[3:0]);
      end
    end
  end

  // divider registers, payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      div_q  <= (full_scale_q == 16'd0) ? 16'd1 : full_scale_q;
      num_q  <= num_init;
      rem_q  <= '0;
      r100_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.step) begin
      num_q  <= num_q << 1;
      rem_q  <= rem_next;
      h_q    <= {h_q[NUM_BITS-2:0], qbit};
      r100_q <= r100_next;
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  // result stage: pending slot feeding the output register
  assign out_load = pend_valid_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        pend_valid_q <= 1'b1;
      end else if (out_load) begin
        pend_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pend_seg_q <= {scan_q == DP_DIGIT, pat_q[scan_q]};
      pend_en_q  <= 4'b0001 << scan_q;
    end
    if (out_load) begin
      out_seg_q <= pend_seg_q;
      out_en_q  <= pend_en_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign segment_lines_o = out_seg_q;
  assign digit_enable_o  = out_en_q;

endmodule

FILE: rtl/accel_axis_seven_segment_readout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_axis_seven_segment_readout
// Accelerometer axis readout on a four-digit multiplexed seven-segment display.
// ----------------------------------------------------------------------------
// Each input transfer is one display tick. A rising edge of the button steps
// the shown axis X, Y, Z, X. The tick's result transfer carries the stored
// pattern of the current digit (decimal point on digit 2) and a one-hot digit
// enable; the four patterns are then refreshed from the selected axis as
// h = floor(|sample| * 200 / full_scale), with the hundreds digit kept when h
// reaches 1000. A full_scale of 0 acts as 1. A tick passes through one accept
// step, one restoring-divider step per quotient bit (SAMPLE_BITS + 8 bits) and
// one step that writes the digit patterns; no new tick is taken meanwhile.
// The result waits in a two-entry output stage; in idle the next tick is
// held off only while both entries are full, that is when the previous
// result is still stalled at the output.
// ----------------------------------------------------------------------------
module accel_axis_seven_segment_readout
  import acc7seg_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   full_scale_we_i,
  input  logic [15:0]            full_scale_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   push_pressed_i,
  input  logic [SAMPLE_BITS-1:0] accel_x_i,
  input  logic [SAMPLE_BITS-1:0] accel_y_i,
  input  logic [SAMPLE_BITS-1:0] accel_z_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             segment_lines_o,
  output logic [3:0]             digit_enable_o
);

  cmd_t    cmd;
  status_t status;

  acc7seg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  acc7seg_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .full_scale_we_i (full_scale_we_i),
    .full_scale_i    (full_scale_i),
    .push_pressed_i  (push_pressed_i),
    .accel_x_i       (accel_x_i),
    .accel_y_i       (accel_y_i),
    .accel_z_i       (accel_z_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .segment_lines_o (segment_lines_o),
    .digit_enable_o  (digit_enable_o)
  );

endmodule
